// File: src/crp_pkg.sv
// Shared types and constants of the Catmull-Rom point and arc-length unit.
`default_nettype none

package crp_pkg;

  // Point table: four banks so that four consecutive points are read in the same cycle
  localparam int MAX_POINTS = 64;
  localparam int BANKS      = 4;
  localparam int BANK_DEPTH = MAX_POINTS / BANKS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int ROOT_W     = 33;

  localparam logic [6:0] COUNT_MIN = 7'd4;
  localparam logic [6:0] COUNT_MAX = 7'(MAX_POINTS);

  // Operation codes carried on in_tuser
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_EVAL    = 2'd1,
    OP_MEASURE = 2'd2
  } op_t;

  // What a job in the pipe is
  typedef enum logic [1:0] {
    KIND_PASS = 2'd0,
    KIND_EVAL = 2'd1,
    KIND_MEAS = 2'd2
  } kind_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_MEAS = 1'b1
  } seq_state_t;

  typedef struct packed {
    kind_t kind;
    logic  first;
    logic  last;
    logic  status;
  } job_t;

  typedef struct packed {
    job_t               job;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } carry_t;

endpackage

`default_nettype wire

// File: src/crp_eval.sv
// Pipelined Catmull-Rom basis evaluation of one 2-D point, six register stages.
`default_nettype none

module crp_eval (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire crp_pkg::job_t          in_job,
  input  wire logic [16:0]            in_u,
  input  wire logic [1:0]             in_base_lo,
  input  wire logic [3:0][31:0]       in_px,
  input  wire logic [3:0][31:0]       in_py,
  output logic                        out_valid,
  output crp_pkg::job_t               out_job,
  output logic signed [31:0]          out_x,
  output logic signed [31:0]          out_y
);

  // stage a: bank reorder, u squared
  logic                va_r;
  crp_pkg::job_t       ja_r;
  logic [3:0][31:0]    pxa_r, pya_r;
  logic [33:0]         uua_r;
  logic [16:0]         ua_r;

  // stage b: t2, u cubed
  logic                vb_r;
  crp_pkg::job_t       jb_r;
  logic [3:0][31:0]    pxb_r, pyb_r;
  logic [25:0]         t2b_r;
  logic [50:0]         u3b_r;
  logic [16:0]         ub_r;

  // stage c: basis weights
  logic                vc_r;
  crp_pkg::job_t       jc_r;
  logic [3:0][31:0]    pxc_r, pyc_r;
  logic signed [28:0]  qc_r [4];
  logic signed [28:0]  q_nxt [4];

  // stage d: products
  logic                vd_r;
  crp_pkg::job_t       jd_r;
  logic signed [60:0]  prx_r [4];
  logic signed [60:0]  pry_r [4];

  // stage e: pair sums
  logic                ve_r;
  crp_pkg::job_t       je_r;
  logic signed [61:0]  sxa_r, sxb_r, sya_r, syb_r;

  // stage f: round, halve, saturate
  logic                vf_r;
  crp_pkg::job_t       jf_r;
  logic signed [31:0]  xf_r, yf_r;

  logic signed [28:0]  t3s, t2s, ss;
  logic [62:0]         accx, accy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  // stage a
  always_ff @(posedge clk) begin
    if (en) begin
      ja_r  <= in_job;
      ua_r  <= in_u;
      uua_r <= in_u * in_u;
      for (int i = 0; i < 4; i++) begin
        pxa_r[i] <= in_px[in_base_lo + 2'(i)];
        pya_r[i] <= in_py[in_base_lo + 2'(i)];
      end
    end
  end

  // stage b
  always_ff @(posedge clk) begin
    if (en) begin
      jb_r  <= ja_r;
      pxb_r <= pxa_r;
      pyb_r <= pya_r;
      ub_r  <= ua_r;
      t2b_r <= uua_r[33:8];
      u3b_r <= 51'(uua_r * ua_r);
    end
  end

  // weights, all terms Q0.24
  always_comb begin
    t3s = signed'({2'b00, u3b_r[50:24]});
    t2s = signed'({3'b000, t2b_r});
    ss  = signed'({4'b0000, ub_r, 8'h00});
    q_nxt[0] = (t2s <<< 1) - t3s - ss;
    q_nxt[1] = (t3s <<< 1) + t3s - (t2s <<< 2) - t2s + (29'sd1 <<< 25);
    q_nxt[2] = (t2s <<< 2) + ss - (t3s <<< 1) - t3s;
    q_nxt[3] = t3s - t2s;
  end

  // stage c
  always_ff @(posedge clk) begin
    if (en) begin
      jc_r  <= jb_r;
      pxc_r <= pxb_r;
      pyc_r <= pyb_r;
      for (int i = 0; i < 4; i++) qc_r[i] <= q_nxt[i];
    end
  end

  // stage d
  always_ff @(posedge clk) begin
    if (en) begin
      jd_r <= jc_r;
      for (int i = 0; i < 4; i++) begin
        prx_r[i] <= signed'(pxc_r[i]) * qc_r[i];
        pry_r[i] <= signed'(pyc_r[i]) * qc_r[i];
      end
    end
  end

  // stage e
  always_ff @(posedge clk) begin
    if (en) begin
      je_r  <= jd_r;
      sxa_r <= {prx_r[0][60], prx_r[0]} + {prx_r[1][60], prx_r[1]};
      sxb_r <= {prx_r[2][60], prx_r[2]} + {prx_r[3][60], prx_r[3]};
      sya_r <= {pry_r[0][60], pry_r[0]} + {pry_r[1][60], pry_r[1]};
      syb_r <= {pry_r[2][60], pry_r[2]} + {pry_r[3][60], pry_r[3]};
    end
  end

  function automatic logic signed [31:0] round_sat(input logic [62:0] acc);
    logic [37:0] sh;
    sh = acc[62:25];
    if ((&sh[37:31]) || !(|sh[37:31])) begin
      round_sat = signed'(sh[31:0]);
    end else if (sh[37]) begin
      round_sat = 32'sh8000_0000;
    end else begin
      round_sat = 32'sh7fff_ffff;
    end
  endfunction

  // acc + 2^24, floor divide by 2^25
  always_comb begin
    accx = {sxa_r[61], sxa_r} + {sxb_r[61], sxb_r} + (63'd1 << 24);
    accy = {sya_r[61], sya_r} + {syb_r[61], syb_r} + (63'd1 << 24);
  end

  // stage f
  always_ff @(posedge clk) begin
    if (en) begin
      jf_r <= je_r;
      xf_r <= round_sat(accx);
      yf_r <= round_sat(accy);
    end
  end

  assign out_valid = vf_r;
  assign out_job   = jf_r;
  assign out_x     = xf_r;
  assign out_y     = yf_r;

endmodule

`default_nettype wire

// File: src/crp_sqrt.sv
// Pipelined integer square root of a 65-bit value, one result bit per stage.
`default_nettype none

module crp_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire crp_pkg::carry_t               in_carry,
  input  wire logic [64:0]                   in_rad,
  output logic                               out_valid,
  output crp_pkg::carry_t                    out_carry,
  output logic [crp_pkg::ROOT_W-1:0]         out_root
);

  localparam int STAGES = crp_pkg::ROOT_W;
  localparam int OPW    = 2 * STAGES;

  logic                           v_r    [STAGES];
  crp_pkg::carry_t                c_r    [STAGES];
  logic [OPW-1:0]                 op_r   [STAGES];
  logic [STAGES+1:0]              rem_r  [STAGES];
  logic [STAGES-1:0]              root_r [STAGES];

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic              pv;
    crp_pkg::carry_t   pc;
    logic [OPW-1:0]    pop;
    logic [STAGES+1:0] prem;
    logic [STAGES-1:0] proot;
    logic [STAGES+3:0] rem_n, trial;

    if (j == 0) begin : g_first
      assign pv    = in_valid;
      assign pc    = in_carry;
      assign pop   = {1'b0, in_rad};
      assign prem  = '0;
      assign proot = '0;
    end else begin : g_next
      assign pv    = v_r[j-1];
      assign pc    = c_r[j-1];
      assign pop   = op_r[j-1];
      assign prem  = rem_r[j-1];
      assign proot = root_r[j-1];
    end

    // bring down the next bit pair, try root*4+1
    assign rem_n = {prem, pop[OPW-1-2*j -: 2]};
    assign trial = {2'b00, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r[j]  <= pc;
        op_r[j] <= pop;
        if (rem_n >= trial) begin
          rem_r[j]  <= (STAGES+2)'(rem_n - trial);
          root_r[j] <= {proot[STAGES-2:0], 1'b1};
        end else begin
          rem_r[j]  <= rem_n[STAGES+1:0];
          root_r[j] <= {proot[STAGES-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_carry = c_r[STAGES-1];
  assign out_root  = root_r[STAGES-1];

endmodule

`default_nettype wire

// File: src/catmull_rom_point_and_arc_length_top.sv
// Top level of the Catmull-Rom point and segment arc-length unit.
//
//   Channel | Ports                          | Carries
//   --------+--------------------------------+-------------------------------------
//   input   | in_tvalid/in_tready/in_tdata/  | write point, evaluate or measure
//           | in_tuser                       |
//   result  | out_tvalid/out_tready/         | point, length and status
//           | out_tdata/out_tuser            |
//   config  | cfg_wr_en/cfg_wr_data          | point_count
//
// Writes and evaluations are taken one per cycle while the pipe is not stalled;
// they pass the issue register, six evaluation stages, three chord stages, 33
// root stages and output. A measurement issues LENGTH_STEPS+1 samples through
// the same pipe, one per cycle unless stalled, holding the input until all issue.
// rst_n is synchronous; the point table has no reset and reads are valid only
// after a write. A stall on out_tready freezes the whole pipe in place.
`default_nettype none

module catmull_rom_point_and_arc_length_top #(
  parameter int LENGTH_STEPS = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // index[5:0], fraction[21:6], x_in[53:22], y_in[85:54], zero pad[87:86]
  input  wire logic [87:0]   in_tdata,
  // operation[1:0]
  input  wire logic [1:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // pos_x[31:0], pos_y[63:32], seg_length[111:64]
  output logic [111:0]       out_tdata,
  // status[0]
  output logic               out_tuser,
  input  wire logic          cfg_wr_en,
  input  wire logic [6:0]    cfg_wr_data
);

  localparam int          KW     = $clog2(LENGTH_STEPS + 1);
  localparam int          FW     = $clog2(LENGTH_STEPS) + 1;
  localparam int          STEP_Q = 65536 / LENGTH_STEPS;
  localparam int          STEP_R = 65536 % LENGTH_STEPS;
  localparam logic [KW-1:0] K_LAST = KW'(LENGTH_STEPS);

  // input fields
  logic [5:0]  in_index;
  logic [15:0] in_fraction;
  logic [31:0] in_x, in_y;
  crp_pkg::op_t in_op;

  assign in_index    = in_tdata[5:0];
  assign in_fraction = in_tdata[21:6];
  assign in_x        = in_tdata[53:22];
  assign in_y        = in_tdata[85:54];
  assign in_op       = crp_pkg::op_t'(in_tuser);

  logic en, accept;
  logic out_tvalid_r;

  assign en     = !out_tvalid_r || out_tready;
  assign accept = in_tvalid && in_tready;

  // point_count register, saturated on write
  logic [6:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= crp_pkg::COUNT_MIN;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < crp_pkg::COUNT_MIN) begin
        count_r <= crp_pkg::COUNT_MIN;
      end else if (cfg_wr_data > crp_pkg::COUNT_MAX) begin
        count_r <= crp_pkg::COUNT_MAX;
      end else begin
        count_r <= cfg_wr_data;
      end
    end
  end

  // range checks
  logic wr_ok, span_ok, meas_start;

  assign wr_ok      = {1'b0, in_index} < count_r;
  assign span_ok    = ({1'b0, in_index} + 7'd3) < count_r;
  assign meas_start = accept && (in_op == crp_pkg::OP_MEASURE) && span_ok;

  // sample sequencer
  crp_pkg::seq_state_t state_r, state_nxt;
  logic [KW-1:0]       k_r;
  logic [16:0]         u_r;
  logic [FW-1:0]       frac_r, frac_sum;
  logic [5:0]          base_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crp_pkg::SEQ_IDLE: begin
        if (meas_start) state_nxt = crp_pkg::SEQ_MEAS;
      end
      crp_pkg::SEQ_MEAS: begin
        if (en && (k_r == K_LAST)) state_nxt = crp_pkg::SEQ_IDLE;
      end
      default: state_nxt = crp_pkg::SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crp_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // u = floor(k*65536/LENGTH_STEPS) kept by quotient and remainder steps
  assign frac_sum = frac_r + FW'(STEP_R);

  always_ff @(posedge clk) begin
    if (meas_start) begin
      k_r    <= KW'(1);
      u_r    <= 17'(STEP_Q);
      frac_r <= FW'(STEP_R);
      base_r <= in_index;
    end else if ((state_r == crp_pkg::SEQ_MEAS) && en && (k_r != K_LAST)) begin
      k_r <= k_r + KW'(1);
      if (frac_sum >= FW'(LENGTH_STEPS)) begin
        u_r    <= u_r + 17'(STEP_Q + 1);
        frac_r <= frac_sum - FW'(LENGTH_STEPS);
      end else begin
        u_r    <= u_r + 17'(STEP_Q);
        frac_r <= frac_sum;
      end
    end
  end

  // issue: handshake and next job
  logic          jv_nxt;
  crp_pkg::job_t job_nxt;
  logic [16:0]   ju_nxt;
  logic [5:0]    rd_base;

  always_comb begin
    in_tready = 1'b0;
    jv_nxt    = 1'b0;
    job_nxt   = '{kind: crp_pkg::KIND_PASS, first: 1'b0, last: 1'b0, status: 1'b1};
    ju_nxt    = '0;
    rd_base   = in_index;
    case (state_r)
      crp_pkg::SEQ_IDLE: begin
        in_tready = en;
        jv_nxt    = accept;
        case (in_op)
          crp_pkg::OP_WRITE: begin
            job_nxt.status = !wr_ok;
          end
          crp_pkg::OP_EVAL: begin
            if (span_ok) begin
              job_nxt.kind   = crp_pkg::KIND_EVAL;
              job_nxt.status = 1'b0;
              ju_nxt         = {1'b0, in_fraction};
            end
          end
          crp_pkg::OP_MEASURE: begin
            if (span_ok) begin
              job_nxt.kind   = crp_pkg::KIND_MEAS;
              job_nxt.first  = 1'b1;
              job_nxt.status = 1'b0;
            end
          end
          default: job_nxt.status = 1'b1;
        endcase
      end
      crp_pkg::SEQ_MEAS: begin
        jv_nxt         = 1'b1;
        job_nxt.kind   = crp_pkg::KIND_MEAS;
        job_nxt.last   = (k_r == K_LAST);
        job_nxt.status = 1'b0;
        ju_nxt         = u_r;
        rd_base        = base_r;
      end
      default: ;
    endcase
  end

  // issue register
  logic          jv_r;
  crp_pkg::job_t job_r;
  logic [16:0]   ju_r;
  logic [1:0]    jbase_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jv_r <= 1'b0;
    end else if (en) begin
      jv_r <= jv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      job_r      <= job_nxt;
      ju_r       <= ju_nxt;
      jbase_lo_r <= rd_base[1:0];
    end
  end

  // point table in four banks, bank = index mod 4
  logic             wr_en;
  logic [3:0][31:0] rd_x, rd_y;

  assign wr_en = accept && (in_op == crp_pkg::OP_WRITE) && wr_ok;

  for (genvar b = 0; b < crp_pkg::BANKS; b++) begin : g_bank
    logic [31:0]                   mem_x [crp_pkg::BANK_DEPTH];
    logic [31:0]                   mem_y [crp_pkg::BANK_DEPTH];
    logic [31:0]                   rdx_r, rdy_r;
    logic [1:0]                    ofs;
    logic [5:0]                    rd_full;
    logic [crp_pkg::BANK_AW-1:0]   rd_addr;

    assign ofs     = 2'(b) - rd_base[1:0];
    assign rd_full = rd_base + {4'b0000, ofs};
    assign rd_addr = rd_full[5:2];

    always_ff @(posedge clk) begin
      if (wr_en && (in_index[1:0] == 2'(b))) begin
        mem_x[in_index[5:2]] <= in_x;
        mem_y[in_index[5:2]] <= in_y;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rdx_r <= mem_x[rd_addr];
        rdy_r <= mem_y[rd_addr];
      end
    end

    assign rd_x[b] = rdx_r;
    assign rd_y[b] = rdy_r;
  end

  // curve evaluation
  logic               ev_valid;
  crp_pkg::job_t      ev_job;
  logic signed [31:0] ev_x, ev_y;

  crp_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (jv_r),
    .in_job     (job_r),
    .in_u       (ju_r),
    .in_base_lo (jbase_lo_r),
    .in_px      (rd_x),
    .in_py      (rd_y),
    .out_valid  (ev_valid),
    .out_job    (ev_job),
    .out_x      (ev_x),
    .out_y      (ev_y)
  );

  // chord stage 1: absolute differences against the previous sample
  logic               cv1_r;
  crp_pkg::carry_t    cc1_r;
  logic [31:0]        ax1_r, ay1_r;
  logic signed [31:0] ox_r, oy_r;
  logic [32:0]        dx, dy;
  logic               ev_meas;

  assign ev_meas = ev_valid && (ev_job.kind == crp_pkg::KIND_MEAS);
  assign dx      = {ev_x[31], ev_x} - {ox_r[31], ox_r};
  assign dy      = {ev_y[31], ev_y} - {oy_r[31], oy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      cc1_r <= '{job: ev_job, pos_x: ev_x, pos_y: ev_y};
      if (ev_job.first) begin
        ax1_r <= '0;
        ay1_r <= '0;
      end else begin
        ax1_r <= dx[32] ? 32'(-dx) : dx[31:0];
        ay1_r <= dy[32] ? 32'(-dy) : dy[31:0];
      end
      if (ev_meas) begin
        ox_r <= ev_x;
        oy_r <= ev_y;
      end
    end
  end

  // chord stage 2: squares
  logic            cv2_r;
  crp_pkg::carry_t cc2_r;
  logic [63:0]     sx2_r, sy2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cc2_r <= cc1_r;
      sx2_r <= ax1_r * ax1_r;
      sy2_r <= ay1_r * ay1_r;
    end
  end

  // chord stage 3: sum of squares
  logic            cv3_r;
  crp_pkg::carry_t cc3_r;
  logic [64:0]     rad3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cc3_r  <= cc2_r;
      rad3_r <= {1'b0, sx2_r} + {1'b0, sy2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv1_r <= 1'b0;
      cv2_r <= 1'b0;
      cv3_r <= 1'b0;
    end else if (en) begin
      cv1_r <= ev_valid;
      cv2_r <= cv1_r;
      cv3_r <= cv2_r;
    end
  end

  // chord length
  logic                          sq_valid;
  crp_pkg::carry_t               sq_carry;
  logic [crp_pkg::ROOT_W-1:0]    sq_root;

  crp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cv3_r),
    .in_carry  (cc3_r),
    .in_rad    (rad3_r),
    .out_valid (sq_valid),
    .out_carry (sq_carry),
    .out_root  (sq_root)
  );

  // length accumulator, saturating at 2^48-1
  logic [47:0] tot_r, tot_nxt;
  logic [48:0] tot_sum;
  logic        sq_meas;

  assign sq_meas = sq_valid && (sq_carry.job.kind == crp_pkg::KIND_MEAS);
  assign tot_sum = (sq_carry.job.first ? 49'd0 : {1'b0, tot_r}) + 49'(sq_root);
  assign tot_nxt = tot_sum[48] ? '1 : tot_sum[47:0];

  always_ff @(posedge clk) begin
    if (en && sq_meas) begin
      tot_r <= tot_nxt;
    end
  end

  // output register; intermediate samples of a measurement give no item
  logic signed [31:0] out_px_r, out_py_r;
  logic [47:0]        out_len_r;
  logic               out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= sq_valid && (!sq_meas || sq_carry.job.last);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r <= sq_carry.job.status;
      if (sq_carry.job.kind == crp_pkg::KIND_EVAL) begin
        out_px_r <= sq_carry.pos_x;
        out_py_r <= sq_carry.pos_y;
      end else begin
        out_px_r <= '0;
        out_py_r <= '0;
      end
      out_len_r <= (sq_carry.job.kind == crp_pkg::KIND_MEAS) ? tot_nxt : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_len_r, out_py_r, out_px_r};
  assign out_tuser  = out_st_r;

endmodule

`default_nettype wire
